/* src/ax25_pkg.sv */
// Shared types, constants and the CRC helper of the AX.25 HDLC framer.
package ax25_pkg;

   // Depth of the command queue between the front and the back end.
   localparam int unsigned CMD_FIFO_DEPTH = 2;

   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [2:0]  STUFF_RUN = 3'd5;
   localparam logic [2:0]  ONES_MAX  = 3'd7;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_FLAG  = 2'd1,
      OP_DATA  = 2'd2,
      OP_FCS   = 2'd3
   } opcode_type;

   // One serializer command: up to sixteen bits, sent LSB first.
   typedef struct packed {
      logic        start;  // frame start: one leading symbol, line state cleared
      logic        flag;   // no bit stuffing
      logic        wide;   // sixteen bits instead of eight
      logic [15:0] bits;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } fifo_stat_type;

   // Reflected CRC-16 over one byte, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ data[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/ax25_front.sv */
// Front end: accepts opcodes, keeps the frame CRC and queues serializer commands.
module ax25_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic [1:0]             req_tuser,   // [1:0] opcode
   input  ax25_pkg::fifo_stat_type fifo_stat,
   output logic                   push,
   output ax25_pkg::cmd_type      push_cmd
);
   import ax25_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        accept;

   assign req_tready = !fifo_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   always_comb begin
      crc_in   = crc_ff;
      push_cmd = '0;
      unique case (opcode_type'(req_tuser))
         OP_START: begin
            crc_in         = CRC_INIT;
            push_cmd.start = 1'b1;
         end
         OP_FLAG: begin
            push_cmd.flag = 1'b1;
            push_cmd.bits = {8'h00, FLAG_BYTE};
         end
         OP_DATA: begin
            crc_in        = crc_byte(crc_ff, req_tdata);
            push_cmd.bits = {8'h00, req_tdata};
         end
         OP_FCS: begin
            // Low byte then high byte of the complement; the CRC moves down a byte.
            crc_in        = crc_ff >> 8;
            push_cmd.wide = 1'b1;
            push_cmd.bits = ~crc_ff;
         end
         default: begin
            crc_in = crc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else if (accept) begin
         crc_ff <= crc_in;
      end
   end

endmodule

/* src/ax25_cmd_fifo.sv */
// Small command queue between the front end and the serializer.
module ax25_cmd_fifo #(
   parameter int unsigned Depth = ax25_pkg::CMD_FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ax25_pkg::cmd_type       push_cmd,
   input  logic                    pop,
   output ax25_pkg::cmd_type       head_cmd,
   output ax25_pkg::fifo_stat_type stat
);
   import ax25_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cmd_type         entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push;
   logic            do_pop;

   assign stat.full  = (count_ff == FullCnt);
   assign stat.valid = (count_ff != '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* src/ax25_back.sv */
// Back end: bit serializer with stuffing, NRZI tone coding and the result register.
module ax25_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ax25_pkg::fifo_stat_type fifo_stat,
   input  ax25_pkg::cmd_type       head_cmd,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // [0] tone, [1] stuffed, [7:2] zero
   output logic                    rsp_tlast
);
   import ax25_pkg::*;

   logic        busy_ff;
   cmd_type     cmd_ff;
   logic [15:0] shift_ff;
   logic [3:0]  idx_ff;
   logic        pend_ff;
   logic [2:0]  ones_ff;
   logic        tone_ff;
   logic        out_valid_ff;
   logic        out_tone_ff;
   logic        out_stuffed_ff;
   logic        out_last_ff;

   logic        adv;
   logic        emit;
   logic        last_bit;
   logic [2:0]  ones_inc;
   logic        tone_in;
   logic [2:0]  ones_in;
   logic        pend_in;
   logic        sym_tone;
   logic        sym_stuffed;
   logic        sym_last;
   logic        done;
   logic        step;
   logic        load;

   assign adv      = !out_valid_ff || rsp_tready;
   assign emit     = busy_ff && adv;
   assign last_bit = (idx_ff == {cmd_ff.wide, 3'b111});
   assign ones_inc = (ones_ff == ONES_MAX) ? ONES_MAX : ones_ff + 1'b1;
   assign load     = fifo_stat.valid && (!busy_ff || (emit && done));
   assign pop      = load;

   always_comb begin
      tone_in     = tone_ff;
      ones_in     = ones_ff;
      pend_in     = pend_ff;
      sym_tone    = tone_ff;
      sym_stuffed = 1'b0;
      sym_last    = 1'b0;
      done        = 1'b0;
      step        = 1'b0;
      if (pend_ff) begin
         // Stuff zero after the fifth one.
         tone_in     = !tone_ff;
         ones_in     = '0;
         pend_in     = 1'b0;
         sym_tone    = !tone_ff;
         sym_stuffed = 1'b1;
         sym_last    = last_bit;
         done        = last_bit;
         step        = 1'b1;
      end else if (cmd_ff.start) begin
         tone_in  = 1'b0;
         ones_in  = '0;
         sym_tone = 1'b0;
         sym_last = 1'b1;
         done     = 1'b1;
      end else if (!shift_ff[0]) begin
         tone_in  = !tone_ff;
         ones_in  = '0;
         sym_tone = !tone_ff;
         sym_last = last_bit;
         done     = last_bit;
         step     = 1'b1;
      end else begin
         ones_in = ones_inc;
         if (!cmd_ff.flag && ones_inc == STUFF_RUN) begin
            pend_in = 1'b1;
         end else begin
            sym_last = last_bit;
            done     = last_bit;
            step     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         ones_ff      <= '0;
         tone_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // A command only finishes with no stuff zero pending, so pend_ff is
         // already clear whenever the next command loads.
         if (emit) begin
            tone_ff <= tone_in;
            ones_ff <= ones_in;
            pend_ff <= pend_in;
         end
         if (load) begin
            busy_ff <= 1'b1;
         end else if (emit && done) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff   <= head_cmd;
         shift_ff <= head_cmd.bits;
         idx_ff   <= '0;
      end else if (emit && step) begin
         shift_ff <= shift_ff >> 1;
         idx_ff   <= idx_ff + 1'b1;
      end
      if (emit) begin
         out_tone_ff    <= sym_tone;
         out_stuffed_ff <= sym_stuffed;
         out_last_ff    <= sym_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_stuffed_ff, out_tone_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

/* src/ax25_hdlc_nrzi_framer.sv */
// The first symbol of a beat passes the queue, command register and output register.
// Throughput: one symbol per cycle while rsp is not stalled; the next command starts
// without a gap: 1 symbol for a frame start, 8 for a flag, 8 to 10 for a data byte,
// 16 to 20 for the FCS; the command queue depth sets how far req can run ahead.
// Reset: synchronous, active high; CRC returns to 0xFFFF, tone and ones count to zero.
module ax25_hdlc_nrzi_framer #(
   parameter int unsigned CmdFifoDepth = ax25_pkg::CMD_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] tone, [1] stuffed, [7:2] zero
   output logic       rsp_tlast    // last symbol caused by the request beat
);
   import ax25_pkg::*;

   // The front end turns each request beat into a serializer command. It owns the
   // CRC, since the CRC depends only on the order of data bytes and not on stuffing:
   // a start resets it, a data byte updates it, an FCS takes its complement, shifts it.
   logic          push;
   cmd_type       push_cmd;
   logic          pop;
   cmd_type       head_cmd;
   fifo_stat_type fifo_stat;

   ax25_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // The queue lets the front take the next beat while the serializer is busy.
   ax25_cmd_fifo #(
      .Depth (CmdFifoDepth)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (fifo_stat)
   );

   // The back end holds the line state (tone and run of ones), sends one symbol
   // per cycle into its output register while rsp is not stalled and inserts a stuff
   // zero after five ones outside flags.
   ax25_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_stat  (fifo_stat),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/ax25_checker.sv */
// Port-level checks of the framer, bound to the top level.
module ax25_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic prev_tone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_tone_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         prev_tone_ff <= rsp_tdata[0];
      end
   end

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // No result right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // Padding bits of the result stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b000000)
      else $error("rsp padding bits set");

   // A stuff zero always flips the tone of the symbol before it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] != prev_tone_ff)
      else $error("stuff symbol did not toggle the tone");

endmodule

bind ax25_hdlc_nrzi_framer ax25_checker u_ax25_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
